// ===== src/cigl_pkg.sv =====
// cigl_pkg: shared types and codes of the codepoint interval glyph lookup
`timescale 1ns / 1ps
`default_nettype none

package cigl_pkg;

    // widths fixed by the item fields
    localparam int CP_W     = 21;
    localparam int GLYPH_W  = 16;
    localparam int SLOT_W   = 8;
    localparam int COUNT_W  = 9;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 21;

    // input action codes
    localparam logic ACT_LOAD   = 1'b0;
    localparam logic ACT_LOOKUP = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPLACEMENT    = 1'b1;

    // reset value of the replacement codepoint
    localparam logic [CP_W-1:0] REPLACEMENT_RESET = 21'd65533;

    // one interval table entry
    typedef struct packed {
        logic [CP_W-1:0]    first;
        logic [CP_W-1:0]    last;
        logic [GLYPH_W-1:0] offset;
    } entry_t;

    // result handed from the search engine to the output stage
    typedef struct packed {
        logic               found;
        logic [GLYPH_W-1:0] glyph_index;
        logic               used_replacement;
    } result_t;

endpackage

`default_nettype wire

// ===== src/cigl_ram.sv =====
// cigl_ram: generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none

module cigl_ram #(
    parameter int WIDTH = 58,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== src/cigl_search.sv =====
// cigl_search: binary search sequencer over the interval ram with replacement retry
`timescale 1ns / 1ps
`default_nettype none

module cigl_search #(
    parameter int MAX_INTERVALS = 256,
    parameter int MAX_GLYPHS    = 65536,
    localparam int IDX_W = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1,
    localparam int CNT_W = $clog2(MAX_INTERVALS + 1)
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    // start of one lookup
    input  wire logic                       start,
    input  wire logic [cigl_pkg::CP_W-1:0]  start_cp,
    input  wire logic [CNT_W-1:0]           start_count,
    input  wire logic [cigl_pkg::CP_W-1:0]  replacement,
    output logic                            idle,
    // ram read port
    output logic                            rd_en,
    output logic [IDX_W-1:0]                rd_addr,
    input  wire cigl_pkg::entry_t           rd_data,
    // finished result
    output logic                            res_valid,
    output cigl_pkg::result_t               res,
    input  wire logic                       res_take
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_STEP,
        S_CHECK,
        S_DONE
    } state_t;

    state_t                      state_reg;
    logic [cigl_pkg::CP_W-1:0]   cp_reg;
    logic [CNT_W-1:0]            count_reg;
    logic [CNT_W-1:0]            base_reg;
    logic [CNT_W-1:0]            len_reg;
    logic [CNT_W-1:0]            mid_reg;
    logic                        retry_reg;
    cigl_pkg::result_t           res_reg;

    logic                        cmp_ge;
    logic [CNT_W-1:0]            half;
    logic [CNT_W-1:0]            plan_base;
    logic [CNT_W-1:0]            plan_len;
    logic [CNT_W-1:0]            plan_mid;
    logic [cigl_pkg::CP_W-1:0]   distance;
    logic [cigl_pkg::CP_W:0]     sum;
    logic                        hit;
    logic                        can_retry;

    // narrow the interval by the entry read last (or start on the whole table), then plan the next read
    always_comb begin
        cmp_ge = (cp_reg >= rd_data.first);
        half   = len_reg >> 1;
        if (state_reg == S_STEP) begin
            if (cmp_ge) begin
                plan_base = mid_reg + CNT_W'(1);
                plan_len  = len_reg - half - CNT_W'(1);
            end else begin
                plan_base = base_reg;
                plan_len  = half;
            end
        end else begin
            plan_base = '0;
            plan_len  = count_reg;
        end
        plan_mid = plan_base + (plan_len >> 1);
        if (plan_len != '0) begin
            rd_addr = IDX_W'(plan_mid);
        end else begin
            rd_addr = IDX_W'(plan_base - CNT_W'(1));
        end
        rd_en = ((state_reg == S_START) || (state_reg == S_STEP))
                && ((plan_len != '0) || (plan_base != '0));
    end

    // hit test on the candidate entry
    always_comb begin
        distance = cp_reg - rd_data.first;
        sum  = {{(cigl_pkg::CP_W + 1 - cigl_pkg::GLYPH_W){1'b0}}, rd_data.offset}
               + {1'b0, distance};
        hit  = (cp_reg >= rd_data.first) && (cp_reg <= rd_data.last)
               && (32'(sum) < 32'(MAX_GLYPHS))
               && (32'(sum) <= 32'h0000_FFFF);
        can_retry = !retry_reg && (cp_reg != replacement);
    end

    // sequencer state and registered result
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            retry_reg <= 1'b0;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (start) begin
                        cp_reg    <= start_cp;
                        count_reg <= start_count;
                        retry_reg <= 1'b0;
                        state_reg <= S_START;
                    end
                end
                S_START, S_STEP: begin
                    base_reg <= plan_base;
                    len_reg  <= plan_len;
                    mid_reg  <= plan_mid;
                    if (plan_len != '0) begin
                        state_reg <= S_STEP;
                    end else if (plan_base != '0) begin
                        state_reg <= S_CHECK;
                    end else if (can_retry) begin
                        cp_reg    <= replacement;
                        retry_reg <= 1'b1;
                        state_reg <= S_START;
                    end else begin
                        res_reg   <= '0;
                        state_reg <= S_DONE;
                    end
                end
                S_CHECK: begin
                    if (hit) begin
                        res_reg.found            <= 1'b1;
                        res_reg.glyph_index      <= sum[cigl_pkg::GLYPH_W-1:0];
                        res_reg.used_replacement <= retry_reg;
                        state_reg                <= S_DONE;
                    end else if (can_retry) begin
                        cp_reg    <= replacement;
                        retry_reg <= 1'b1;
                        state_reg <= S_START;
                    end else begin
                        res_reg   <= '0;
                        state_reg <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (res_take) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign idle      = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;

endmodule

`default_nettype wire

// ===== src/codepoint_interval_glyph_lookup_top.sv =====
// codepoint_interval_glyph_lookup_top: interval table glyph lookup, top level
//
//   channel   dir  handshake          payload
//   s_        in   s_valid/s_ready    action, entry_index, interval_first/last,
//                                     glyph_offset, codepoint
//   m_        out  m_valid/m_ready    found, glyph_index, used_replacement
//   cfg_      in   cfg_wr_en          cfg_index, cfg_wr_data
//
// a load beat writes the table ram at acceptance; the next beat can follow at once.
// a search pass is start, binary search ram reads and a hit check; a miss is retried
// once with the replacement codepoint unless the codepoint already is the replacement;
// the single ram read port serializes the reads; s_ready is low while a lookup runs.
// a finished result sits in the output register while the next beat is accepted.
// reset clears control state only; the table is undefined until loaded.
`timescale 1ns / 1ps
`default_nettype none

module codepoint_interval_glyph_lookup_top #(
    parameter int MAX_INTERVALS = 256,
    parameter int MAX_GLYPHS    = 65536
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // configuration
    input  wire logic                              cfg_wr_en,
    input  wire logic [cigl_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [cigl_pkg::CFG_DATA_W-1:0]   cfg_wr_data,
    // input beats
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic                              s_action,
    input  wire logic [cigl_pkg::SLOT_W-1:0]       s_entry_index,
    input  wire logic [cigl_pkg::CP_W-1:0]         s_interval_first,
    input  wire logic [cigl_pkg::CP_W-1:0]         s_interval_last,
    input  wire logic [cigl_pkg::GLYPH_W-1:0]      s_glyph_offset,
    input  wire logic [cigl_pkg::CP_W-1:0]         s_codepoint,
    // result beats
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic                                   m_found,
    output logic [cigl_pkg::GLYPH_W-1:0]           m_glyph_index,
    output logic                                   m_used_replacement
);

    localparam int IDX_W = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
    localparam int CNT_W = $clog2(MAX_INTERVALS + 1);

    logic [cigl_pkg::COUNT_W-1:0]  count_reg;
    logic [cigl_pkg::CP_W-1:0]     repl_reg;
    logic [CNT_W-1:0]              count_eff;

    logic                          in_beat;
    logic                          idle;
    logic                          wr_en;
    logic [IDX_W-1:0]              wr_addr;
    cigl_pkg::entry_t              wr_entry;
    logic                          rd_en;
    logic [IDX_W-1:0]              rd_addr;
    cigl_pkg::entry_t              rd_data;

    logic                          res_valid;
    cigl_pkg::result_t             res;
    logic                          res_take;

    logic                          m_valid_reg;
    cigl_pkg::result_t             out_reg;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            repl_reg  <= cigl_pkg::REPLACEMENT_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                cigl_pkg::CFG_INTERVAL_COUNT: count_reg <= cfg_wr_data[cigl_pkg::COUNT_W-1:0];
                cigl_pkg::CFG_REPLACEMENT:    repl_reg  <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // count clamped to the table capacity
    assign count_eff = (32'(count_reg) > 32'(MAX_INTERVALS)) ? CNT_W'(MAX_INTERVALS)
                                                              : CNT_W'(count_reg);

    // input beat acceptance and table load
    assign s_ready  = idle;
    assign in_beat  = s_valid && s_ready;
    assign wr_en    = in_beat && (s_action == cigl_pkg::ACT_LOAD)
                      && (32'(s_entry_index) < 32'(MAX_INTERVALS));
    assign wr_addr  = IDX_W'(32'(s_entry_index));
    assign wr_entry = '{first: s_interval_first, last: s_interval_last,
                        offset: s_glyph_offset};

    cigl_ram #(
        .WIDTH ($bits(cigl_pkg::entry_t)),
        .DEPTH (MAX_INTERVALS)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_entry),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    cigl_search #(
        .MAX_INTERVALS (MAX_INTERVALS),
        .MAX_GLYPHS    (MAX_GLYPHS)
    ) u_search (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start       (in_beat && (s_action == cigl_pkg::ACT_LOOKUP)),
        .start_cp    (s_codepoint),
        .start_count (count_eff),
        .replacement (repl_reg),
        .idle        (idle),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr),
        .rd_data     (rd_data),
        .res_valid   (res_valid),
        .res         (res),
        .res_take    (res_take)
    );

    // output register, refilled when empty or drained this cycle
    assign res_take = res_valid && (!m_valid_reg || m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_take) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_take) begin
            out_reg <= res;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_found            = out_reg.found;
    assign m_glyph_index      = out_reg.glyph_index;
    assign m_used_replacement = out_reg.used_replacement;

endmodule

`default_nettype wire
